// ===== sv/floor_ceiling_texel_caster_core_macros.svh =====
// assertion macros for the floor and ceiling texel caster
`ifndef FLOOR_CEILING_TEXEL_CASTER_CORE_MACROS_SVH
`define FLOOR_CEILING_TEXEL_CASTER_CORE_MACROS_SVH

// implication checked on every clock edge outside reset
`define FCTC_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// implication whose consequent is checked in the cycle after the antecedent
`define FCTC_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== sv/fctc_pkg.sv =====
// types and constants of the floor and ceiling texel caster
`default_nettype none
package fctc_pkg;
	localparam int FRAC_BITS = 16;
	localparam int MAP_BITS  = 8;
	localparam logic [16:0] ONE_FIX = 17'h10000;

	localparam logic [2:0] REG_SCREEN_HEIGHT = 3'd0;
	localparam logic [2:0] REG_FLOOR_TEX_W   = 3'd1;
	localparam logic [2:0] REG_FLOOR_TEX_H   = 3'd2;
	localparam logic [2:0] REG_SKY_TEX_W     = 3'd3;
	localparam logic [2:0] REG_SKY_TEX_H     = 3'd4;

	typedef struct packed {
		logic [24:0] fx;
		logic [24:0] fy;
		logic [23:0] px;
		logic [23:0] py;
		logic        drawn;
		logic [11:0] ceil_row;
	} item_t;

	typedef struct packed {
		item_t       itm;
		logic [35:0] den;
		logic [43:0] rem;
		logic [15:0] quo;
		logic        sat;
	} div_t;
endpackage
`default_nettype wire

// ===== sv/fctc_ifs.sv =====
// channel interfaces of the floor and ceiling texel caster
`default_nettype none
interface fctc_in_if;
	logic        valid;
	logic        ready;
	logic        hit_side;
	logic        ray_x_positive;
	logic        ray_y_positive;
	logic [7:0]  cell_x;
	logic [7:0]  cell_y;
	logic [15:0] hit_fraction;
	logic [23:0] wall_distance;
	logic signed [11:0] wall_bottom_row;
	logic [10:0] screen_row;
	logic [23:0] player_x;
	logic [23:0] player_y;

	modport source (output valid, hit_side, ray_x_positive, ray_y_positive, cell_x, cell_y,
		hit_fraction, wall_distance, wall_bottom_row, screen_row, player_x, player_y,
		input ready);
	modport sink (input valid, hit_side, ray_x_positive, ray_y_positive, cell_x, cell_y,
		hit_fraction, wall_distance, wall_bottom_row, screen_row, player_x, player_y,
		output ready);
endinterface

interface fctc_out_if;
	logic        valid;
	logic        ready;
	logic [9:0]  floor_texel_x;
	logic [9:0]  floor_texel_y;
	logic [9:0]  sky_texel_x;
	logic [9:0]  sky_texel_y;
	logic [11:0] ceiling_row;
	logic        drawn;

	modport source (output valid, floor_texel_x, floor_texel_y, sky_texel_x, sky_texel_y,
		ceiling_row, drawn, input ready);
	modport sink (input valid, floor_texel_x, floor_texel_y, sky_texel_x, sky_texel_y,
		ceiling_row, drawn, output ready);
endinterface
`default_nettype wire

// ===== sv/fctc_mod.sv =====
// three-stage modulo reduction of a texel index by the texture size
`default_nettype none
module fctc_mod
	import fctc_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        en,
	input  wire logic [19:0] t,
	input  wire logic [10:0] size,
	output logic [10:0]      res
);
	// t < size * 512, so nine conditional subtracts leave t mod size
	function automatic logic [19:0] reduce3(input logic [19:0] v, input logic [10:0] sz,
		input int hi);
		logic [19:0] acc;
		logic [19:0] sh;
		acc = v;
		for (int i = 0; i < 3; i++) begin
			sh = 20'(sz) << (hi - i);
			if (acc >= sh) begin
				acc = acc - sh;
			end
		end
		return acc;
	endfunction

	logic [19:0] t_s1, t_s2, t_s3;

	always_ff @(posedge clk) begin
		if (en) begin
			t_s1 <= reduce3(t, size, 8);
			t_s2 <= reduce3(t_s1, size, 5);
			t_s3 <= reduce3(t_s2, size, 2);
		end
	end

	assign res = t_s3[10:0];
endmodule
`default_nettype wire

// ===== sv/floor_ceiling_texel_caster_core.sv =====
// top level of the floor and ceiling texel caster
// Floor and ceiling texel caster: one screen pixel in, one texel result out.
// in_ch carries the wall hit of a column, the screen row and the player
// position; out_ch returns floor and sky texel coordinates, the mirrored
// ceiling row and the drawn flag. Transfers are valid/ready on both sides.
// The pipeline takes one pixel per cycle while out_ch does not stall
// with a result waiting. The depth is set by the row-distance divider,
// which retires one quotient bit per stage over sixteen stages, followed
// by the blend multipliers and a three-stage modulo reducer per texel.
// The whole pipeline advances together: when out_ch stalls with a result
// waiting, in_ch.ready falls in the same cycle and every stage holds.
// Pixels that are not drawn come out with all texel fields zero.
// Registers are written through cfg_we/cfg_index/cfg_wdata; indexes above
// the sky texture height are ignored. Write them only while no pixel is
// in flight. Reset (arst_n low) empties the pipeline and loads a screen
// height of 480 and texture sizes of 64.
`default_nettype none
`include "floor_ceiling_texel_caster_core_macros.svh"
module floor_ceiling_texel_caster_core
	import fctc_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	fctc_in_if.sink          in_ch,
	fctc_out_if.source       out_ch,
	input  wire logic        cfg_we,
	input  wire logic [2:0]  cfg_index,
	input  wire logic [11:0] cfg_wdata
);
	logic [11:0] height_q;
	logic [10:0] ftw_q, fth_q, stw_q, sth_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			height_q <= 12'd480;
			ftw_q    <= 11'd64;
			fth_q    <= 11'd64;
			stw_q    <= 11'd64;
			sth_q    <= 11'd64;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_SCREEN_HEIGHT: height_q <= cfg_wdata;
				REG_FLOOR_TEX_W:   ftw_q    <= cfg_wdata[10:0];
				REG_FLOOR_TEX_H:   fth_q    <= cfg_wdata[10:0];
				REG_SKY_TEX_W:     stw_q    <= cfg_wdata[10:0];
				REG_SKY_TEX_H:     sth_q    <= cfg_wdata[10:0];
				default: ;
			endcase
		end
	end

	localparam int NDIV = FRAC_BITS;
	localparam int NVLD = NDIV + 9;

	logic en;
	logic out_vld_q;
	logic [NVLD-1:0] vld_q;

	assign en = !out_vld_q || out_ch.ready;
	assign in_ch.ready = en;

	// stage 1: wall foot point, flags, row distance denominator term
	item_t       itm_c, itm_s1, itm_s2;
	logic [24:0] cx, cy;
	logic [11:0] diff_s1;
	logic [23:0] wdist_s1;
	logic [35:0] den_s2;

	always_comb begin
		cx = {1'b0, in_ch.cell_x, 16'h0};
		cy = {1'b0, in_ch.cell_y, 16'h0};
		itm_c.px = in_ch.player_x;
		itm_c.py = in_ch.player_y;
		if (!in_ch.hit_side) begin
			itm_c.fx = in_ch.ray_x_positive ? cx : cx + 25'(ONE_FIX);
			itm_c.fy = cy + 25'(in_ch.hit_fraction);
		end else begin
			itm_c.fx = cx + 25'(in_ch.hit_fraction);
			itm_c.fy = in_ch.ray_y_positive ? cy : cy + 25'(ONE_FIX);
		end
		itm_c.drawn = ($signed({1'b0, in_ch.screen_row}) > in_ch.wall_bottom_row)
			&& ({1'b0, in_ch.screen_row} < height_q)
			&& ({in_ch.screen_row, 1'b0} > height_q);
		itm_c.ceil_row = ({1'b0, in_ch.screen_row} <= height_q)
			? height_q - {1'b0, in_ch.screen_row} : 12'd0;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			itm_s1   <= itm_c;
			diff_s1  <= {in_ch.screen_row, 1'b0} - height_q;
			wdist_s1 <= in_ch.wall_distance;
			itm_s2   <= itm_s1;
			den_s2   <= 36'(diff_s1) * 36'(wdist_s1);
		end
	end

	// stage 3 onward: saturation check, then one quotient bit per stage
	div_t dv_s3 [0:NDIV];

	always_ff @(posedge clk) begin
		if (en) begin
			dv_s3[0].itm <= itm_s2;
			dv_s3[0].den <= den_s2;
			dv_s3[0].rem <= {height_q, 32'h0};
			dv_s3[0].quo <= '0;
			dv_s3[0].sat <= (den_s2 == 36'd0) || (36'({height_q, 16'h0}) >= den_s2);
		end
	end

	for (genvar k = 0; k < NDIV; k++) begin : g_div
		localparam int B = NDIV - 1 - k;
		logic [51:0] dsh;
		logic        take;
		assign dsh  = 52'(dv_s3[k].den) << B;
		assign take = {8'h0, dv_s3[k].rem} >= dsh;
		always_ff @(posedge clk) begin
			if (en) begin
				dv_s3[k+1].itm <= dv_s3[k].itm;
				dv_s3[k+1].den <= dv_s3[k].den;
				dv_s3[k+1].sat <= dv_s3[k].sat;
				dv_s3[k+1].rem <= take ? dv_s3[k].rem - dsh[43:0] : dv_s3[k].rem;
				dv_s3[k+1].quo <= dv_s3[k].quo | (take ? (16'd1 << B) : 16'd0);
			end
		end
	end

	// blend products, blended positions, texel products
	logic [16:0] w, wn;
	item_t       itm_s20, itm_s21, itm_s22;
	logic [41:0] wfx_s20, wfy_s20;
	logic [40:0] wpx_s20, wpy_s20;
	logic [24:0] posx_s21, posy_s21;
	logic [42:0] sumx, sumy;
	logic [35:0] pftw, pfth, pstw, psth;
	logic [19:0] tftw_s22, tfth_s22, tstw_s22, tsth_s22;

	assign w  = dv_s3[NDIV].sat ? ONE_FIX : {1'b0, dv_s3[NDIV].quo};
	assign wn = ONE_FIX - w;
	assign sumx = 43'(wfx_s20) + 43'(wpx_s20);
	assign sumy = 43'(wfy_s20) + 43'(wpy_s20);
	assign pftw = 36'(posx_s21) * 36'(ftw_q);
	assign pfth = 36'(posy_s21) * 36'(fth_q);
	assign pstw = 36'(posx_s21) * 36'(stw_q);
	assign psth = 36'(posy_s21) * 36'(sth_q);

	always_ff @(posedge clk) begin
		if (en) begin
			itm_s20  <= dv_s3[NDIV].itm;
			wfx_s20  <= 42'(w) * 42'(dv_s3[NDIV].itm.fx);
			wfy_s20  <= 42'(w) * 42'(dv_s3[NDIV].itm.fy);
			wpx_s20  <= 41'(wn) * 41'(dv_s3[NDIV].itm.px);
			wpy_s20  <= 41'(wn) * 41'(dv_s3[NDIV].itm.py);
			itm_s21  <= itm_s20;
			posx_s21 <= sumx[40:16];
			posy_s21 <= sumy[40:16];
			itm_s22  <= itm_s21;
			tftw_s22 <= pftw[35:16];
			tfth_s22 <= pfth[35:16];
			tstw_s22 <= pstw[35:16];
			tsth_s22 <= psth[35:16];
		end
	end

	logic [10:0] m_ftw, m_fth, m_stw, m_sth;

	fctc_mod u_mod_ftw (.clk(clk), .en(en), .t(tftw_s22), .size(ftw_q), .res(m_ftw));
	fctc_mod u_mod_fth (.clk(clk), .en(en), .t(tfth_s22), .size(fth_q), .res(m_fth));
	fctc_mod u_mod_stw (.clk(clk), .en(en), .t(tstw_s22), .size(stw_q), .res(m_stw));
	fctc_mod u_mod_sth (.clk(clk), .en(en), .t(tsth_s22), .size(sth_q), .res(m_sth));

	// row flags ride alongside the reducer
	logic        drawn_s23 [0:2];
	logic [11:0] ceil_s23  [0:2];

	always_ff @(posedge clk) begin
		if (en) begin
			drawn_s23[0] <= itm_s22.drawn;
			ceil_s23[0]  <= itm_s22.ceil_row;
			for (int i = 1; i < 3; i++) begin
				drawn_s23[i] <= drawn_s23[i-1];
				ceil_s23[i]  <= ceil_s23[i-1];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q     <= '0;
			out_vld_q <= 1'b0;
		end else if (en) begin
			vld_q     <= {vld_q[NVLD-2:0], in_ch.valid};
			out_vld_q <= vld_q[NVLD-1];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			out_ch.floor_texel_x <= drawn_s23[2] ? m_ftw[9:0] : 10'd0;
			out_ch.floor_texel_y <= drawn_s23[2] ? m_fth[9:0] : 10'd0;
			out_ch.sky_texel_x   <= drawn_s23[2] ? m_stw[9:0] : 10'd0;
			out_ch.sky_texel_y   <= drawn_s23[2] ? m_sth[9:0] : 10'd0;
			out_ch.ceiling_row   <= ceil_s23[2];
			out_ch.drawn         <= drawn_s23[2];
		end
	end

	assign out_ch.valid = out_vld_q;

	`FCTC_ASSERT_IMP(a_undrawn_zero, clk, arst_n, out_vld_q && !out_ch.drawn,
		(out_ch.floor_texel_x == 10'd0) && (out_ch.sky_texel_y == 10'd0),
		"undrawn pixel with nonzero texel")
	`FCTC_ASSERT_IMP(a_ceil_mirror, clk, arst_n, out_vld_q && out_ch.drawn,
		({out_ch.ceiling_row, 1'b0} < {1'b0, height_q}),
		"drawn pixel with ceiling row below the mirror")
	`FCTC_ASSERT_IMP(a_texel_range, clk, arst_n,
		out_vld_q && out_ch.drawn && (ftw_q != 11'd0) && (ftw_q <= 11'd1024),
		({1'b0, out_ch.floor_texel_x} < ftw_q), "floor texel beyond texture width")
	`FCTC_ASSERT_NEXT(a_stall_hold, clk, arst_n, out_vld_q && !out_ch.ready,
		out_vld_q && $stable(vld_q), "pipeline moved during a stall")
endmodule
`default_nettype wire
